/* rtl/nmi_pkg.sv */
`timescale 1ns / 1ps
// Shared types and codes for the normalized mutual information block.
// No dependencies; used by nmi_ctrl, nmi_dp and the top level.
package nmi_pkg;

  localparam logic [1:0] REQ_ROW    = 2'd0;
  localparam logic [1:0] REQ_COL    = 2'd1;
  localparam logic [1:0] REQ_JOINT  = 2'd2;
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_EMPTY      = 2'd1;
  localparam logic [1:0] ST_DEGENERATE = 2'd2;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] bin_count;
    logic [31:0] total_count;
    logic        last;
  } in_t;

  typedef struct packed {
    logic [31:0] nmi_value;
    logic [1:0]  status;
  } out_t;

  typedef enum logic [3:0] {
    S_IDLE, S_CHK, S_DIV, S_NORM, S_IDX, S_ROM, S_INTERP, S_UFM, S_MUL, S_ACC,
    S_FIN, S_NDIV, S_OUT
  } state_t;

  typedef struct packed {
    logic load;
    logic div_step;
    logic norm_step;
    logic idx;
    logic rom;
    logic interp;
    logic ufm;
    logic mul;
    logic acc;
    logic fin;
    logic nd_step;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic contrib;
    logic last;
    logic cnt_done;
    logic norm_done;
    logic fin_short;
    logic out_free;
  } sts_t;

endpackage

/* rtl/normalized_mutual_information.sv */
`timescale 1ns / 1ps
// Normalized mutual information from streamed histogram bins; top level.
// One transaction at a time: a zero or saturated bin skips the arithmetic; a counted bin
// runs the 32-step ratio divider, up to 31 normalize shifts and 6 further steps.
// A last bin adds the 32-step result divider (skipped if short) and the output load.
// Synchronous active-low reset clears the controller, the three sums and out_valid.
module normalized_mutual_information #(
  parameter int COUNT_WIDTH       = 32,
  parameter int LOG_TABLE_ENTRIES = 1024
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  nmi_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output nmi_pkg::out_t out_data
);

  nmi_pkg::cmd_t cmd;
  nmi_pkg::sts_t sts;

  nmi_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  nmi_dp #(
    .COUNT_WIDTH       (COUNT_WIDTH),
    .LOG_TABLE_ENTRIES (LOG_TABLE_ENTRIES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

/* rtl/nmi_ctrl.sv */
`timescale 1ns / 1ps
// Controller state machine for the normalized mutual information block.
// Depends on nmi_pkg; drives nmi_dp through command and status structs.
module nmi_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  nmi_pkg::sts_t sts,
  output nmi_pkg::cmd_t cmd
);

  nmi_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= nmi_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      nmi_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = nmi_pkg::S_CHK;
        end
      end
      nmi_pkg::S_CHK: begin
        if (sts.contrib) state_nxt = nmi_pkg::S_DIV;
        else if (sts.last) state_nxt = nmi_pkg::S_FIN;
        else state_nxt = nmi_pkg::S_IDLE;
      end
      nmi_pkg::S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.cnt_done) state_nxt = nmi_pkg::S_NORM;
      end
      nmi_pkg::S_NORM: begin
        if (sts.norm_done) state_nxt = nmi_pkg::S_IDX;
        else cmd.norm_step = 1'b1;
      end
      nmi_pkg::S_IDX: begin
        cmd.idx   = 1'b1;
        state_nxt = nmi_pkg::S_ROM;
      end
      nmi_pkg::S_ROM: begin
        cmd.rom   = 1'b1;
        state_nxt = nmi_pkg::S_INTERP;
      end
      nmi_pkg::S_INTERP: begin
        cmd.interp = 1'b1;
        state_nxt  = nmi_pkg::S_UFM;
      end
      nmi_pkg::S_UFM: begin
        cmd.ufm   = 1'b1;
        state_nxt = nmi_pkg::S_MUL;
      end
      nmi_pkg::S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = nmi_pkg::S_ACC;
      end
      nmi_pkg::S_ACC: begin
        cmd.acc   = 1'b1;
        state_nxt = sts.last ? nmi_pkg::S_FIN : nmi_pkg::S_IDLE;
      end
      nmi_pkg::S_FIN: begin
        cmd.fin   = 1'b1;
        state_nxt = sts.fin_short ? nmi_pkg::S_OUT : nmi_pkg::S_NDIV;
      end
      nmi_pkg::S_NDIV: begin
        cmd.nd_step = 1'b1;
        if (sts.cnt_done) state_nxt = nmi_pkg::S_OUT;
      end
      nmi_pkg::S_OUT: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = nmi_pkg::S_IDLE;
        end
      end
      default: state_nxt = nmi_pkg::S_IDLE;
    endcase
  end

endmodule

/* rtl/nmi_dp.sv */
`timescale 1ns / 1ps
// Datapath: bit-serial dividers, normalizer, log table, p*log p and the sums.
// Depends on nmi_pkg; sequenced by nmi_ctrl.
module nmi_dp #(
  parameter int COUNT_WIDTH       = 32,
  parameter int LOG_TABLE_ENTRIES = 1024
) (
  input  logic          clk,
  input  logic          rst_n,
  input  nmi_pkg::in_t  in_data,
  input  logic          out_ready,
  output logic          out_valid,
  output nmi_pkg::out_t out_data,
  input  nmi_pkg::cmd_t cmd,
  output nmi_pkg::sts_t sts
);

  localparam int AW = $clog2(LOG_TABLE_ENTRIES + 1);
  localparam int NW = $clog2(LOG_TABLE_ENTRIES + 1);
  localparam int XW = 31 + NW;
  localparam logic [31:0] CNT_MASK = (COUNT_WIDTH >= 32) ? 32'hFFFF_FFFF :
                                     32'((64'd1 << COUNT_WIDTH) - 64'd1);
  localparam logic [AW-1:0] IDX_MAX = AW'(LOG_TABLE_ENTRIES - 1);
  localparam logic [NW-1:0] N_C     = NW'(LOG_TABLE_ENTRIES);

  // Fraction of log2(m) in Q0.40 by repeated squaring, m in Q1.31.
  function automatic logic [39:0] log2_frac(input logic [63:0] m_in);
    logic [63:0] m;
    logic [39:0] f;
    m = m_in;
    f = '0;
    for (int b = 39; b >= 0; b--) begin
      m = (m * m) >> 31;
      if (m >= 64'h1_0000_0000) begin
        m    = m >> 1;
        f[b] = 1'b1;
      end
    end
    return f;
  endfunction

  logic [40:0] rom_c [0:LOG_TABLE_ENTRIES];

  for (genvar gi = 0; gi < LOG_TABLE_ENTRIES; gi++) begin : g_rom
    assign rom_c[gi] = {1'b0, log2_frac(64'h8000_0000 +
                                        ((64'(gi) << 31) / LOG_TABLE_ENTRIES))};
  end
  assign rom_c[LOG_TABLE_ENTRIES] = 41'h100_0000_0000;

  logic [1:0]  rt_r;
  logic [31:0] bin_r, tot_r;
  logic        last_r;
  logic [4:0]  cnt_r;
  logic [32:0] drem_r;
  logic [31:0] q_r, m_r;
  logic [4:0]  e_r;
  logic [XW-1:0] x_r;
  logic [40:0] lo_r, hi_r;
  logic [15:0] w_r;
  logic [56:0] dw_r;
  logic [45:0] u_r;
  logic [45:0] p1_r;
  logic [63:0] p2_r;
  logic signed [47:0] row_r, col_r, jnt_r;
  logic [49:0] nrem_r;
  logic [47:0] b_r;
  logic [31:0] val_r;
  logic [1:0]  stat_r;
  logic        out_valid_r;
  nmi_pkg::out_t out_r;

  // Ratio divider step.
  logic [32:0] d_sh;
  logic        d_ge;
  logic [31:0] q_nxt;
  assign d_sh  = {drem_r[31:0], 1'b0};
  assign d_ge  = d_sh >= {1'b0, tot_r};
  assign q_nxt = {q_r[30:0], d_ge};

  // Table index and interpolation weight.
  logic [AW-1:0] idx_raw, idx;
  assign idx_raw = AW'(x_r[XW-1:31]);
  assign idx     = (idx_raw > IDX_MAX) ? IDX_MAX : idx_raw;

  logic [40:0] diff, lval;
  assign diff = (hi_r > lo_r) ? (hi_r - lo_r) : '0;
  assign lval = lo_r + dw_r[56:16];

  logic [46:0] mag;
  assign mag = {1'b0, p1_r} + {15'd0, p2_r[63:32]};

  logic signed [47:0] cur;
  logic signed [48:0] s49;
  logic signed [47:0] snew;
  always_comb begin
    case (rt_r)
      nmi_pkg::REQ_ROW: cur = row_r;
      nmi_pkg::REQ_COL: cur = col_r;
      default:          cur = jnt_r;
    endcase
    s49  = $signed({cur[47], cur}) - $signed({2'b00, mag});
    snew = (s49[48] && !s49[47]) ? 48'sh8000_0000_0000 : s49[47:0];
  end

  // Final ratio operands.
  logic [48:0] asum;
  logic [49:0] a50;
  logic [47:0] b48;
  logic        b_zero, sat;
  assign asum   = 49'($signed({row_r[47], row_r}) + $signed({col_r[47], col_r}));
  assign a50    = 50'd0 - {asum[48], asum};
  assign b48    = 48'd0 - jnt_r;
  assign b_zero = (b48 == '0);
  assign sat    = a50 >= {b48, 2'b00};

  logic [49:0] n_sh, n_trial;
  logic        n_ge;
  assign n_sh    = (cnt_r >= 5'd2) ? {nrem_r[48:0], 1'b0} : nrem_r;
  assign n_trial = (cnt_r == 5'd0) ? {1'b0, b_r, 1'b0} : {2'b00, b_r};
  assign n_ge    = n_sh >= n_trial;

  logic out_free;
  assign out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rt_r   <= in_data.req_type;
      bin_r  <= in_data.bin_count & CNT_MASK;
      tot_r  <= in_data.total_count & CNT_MASK;
      last_r <= in_data.last;
      drem_r <= {1'b0, in_data.bin_count & CNT_MASK};
      q_r    <= '0;
    end
    if (cmd.div_step) begin
      drem_r <= d_ge ? (d_sh - {1'b0, tot_r}) : d_sh;
      q_r    <= q_nxt;
      m_r    <= q_nxt;
      e_r    <= 5'd31;
    end
    if (cmd.norm_step) begin
      m_r <= {m_r[30:0], 1'b0};
      e_r <= e_r - 5'd1;
    end
    if (cmd.idx) x_r <= XW'(m_r[30:0]) * XW'(N_C);
    if (cmd.rom) begin
      lo_r <= rom_c[idx];
      hi_r <= rom_c[idx + AW'(1)];
      w_r  <= x_r[30:15];
    end
    if (cmd.interp) dw_r <= 57'(diff) * 57'(w_r);
    if (cmd.ufm) u_r <= ({6'd32 - {1'b0, e_r}, 40'd0}) - {5'd0, lval};
    if (cmd.mul) begin
      p1_r <= 46'(q_r) * 46'(u_r[45:32]);
      p2_r <= 64'(q_r) * 64'(u_r[31:0]);
    end
    if (cmd.fin) begin
      nrem_r <= a50;
      b_r    <= b48;
      val_r  <= '0;
      if (tot_r == '0) begin
        stat_r <= nmi_pkg::ST_EMPTY;
      end else if (b_zero) begin
        stat_r <= nmi_pkg::ST_DEGENERATE;
      end else begin
        stat_r <= nmi_pkg::ST_OK;
        if (sat) val_r <= 32'hFFFF_FFFF;
      end
    end
    if (cmd.nd_step) begin
      nrem_r <= n_ge ? (n_sh - n_trial) : n_sh;
      val_r  <= {val_r[30:0], n_ge};
    end
    if (cmd.emit) begin
      out_r.nmi_value <= val_r;
      out_r.status    <= stat_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      row_r       <= '0;
      col_r       <= '0;
      jnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.load || cmd.fin) cnt_r <= '0;
      else if (cmd.div_step || cmd.nd_step) cnt_r <= cnt_r + 5'd1;
      if (cmd.acc) begin
        case (rt_r)
          nmi_pkg::REQ_ROW: row_r <= snew;
          nmi_pkg::REQ_COL: col_r <= snew;
          default:          jnt_r <= snew;
        endcase
      end
      if (cmd.emit) begin
        row_r       <= '0;
        col_r       <= '0;
        jnt_r       <= '0;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign sts.contrib   = (tot_r != '0) && (bin_r != '0) && (bin_r < tot_r) &&
                         (rt_r != nmi_pkg::REQ_UNUSED);
  assign sts.last      = last_r;
  assign sts.cnt_done  = (cnt_r == 5'd31);
  assign sts.norm_done = m_r[31];
  assign sts.fin_short = (tot_r == '0) || b_zero || sat;
  assign sts.out_free  = out_free;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
